// ----- src/rtsp_response_framer_core_defines.svh -----
// assertion macros shared by the rtsp response framer modules
`ifndef RTSP_RESPONSE_FRAMER_CORE_DEFINES_SVH
`define RTSP_RESPONSE_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, checked on every clock edge out of reset
`define RRF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every clock edge out of reset
`define RRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/rrf_pkg.sv -----
// shared types, constants and helper functions for the rtsp response framer
package rrf_pkg;

   // widths
   localparam int unsigned LENGTH_WIDTH_DEFAULT = 32;
   localparam int unsigned LIMIT_WIDTH          = 17;
   localparam int unsigned CSR_INDEX_WIDTH      = 2;
   localparam int unsigned FRAME_LEN_WIDTH      = 16;
   localparam int unsigned LINE_STATE_WIDTH     = 5;

   // header limit bounds and prefix handling
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MIN    = 17'd4;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX    = 17'h10000;
   localparam logic [LIMIT_WIDTH-1:0] PREFIX_COUNT = 17'd4;
   localparam logic [39:0]            PREFIX_WORD  = 40'h525453502F;

   // byte codes
   localparam logic [7:0] BYTE_DOLLAR  = 8'h24;
   localparam logic [7:0] BYTE_CR      = 8'h0D;
   localparam logic [7:0] BYTE_LF      = 8'h0A;
   localparam logic [7:0] BYTE_TAB     = 8'h09;
   localparam logic [7:0] BYTE_VT      = 8'h0B;
   localparam logic [7:0] BYTE_FF      = 8'h0C;
   localparam logic [7:0] BYTE_SPACE   = 8'h20;
   localparam logic [7:0] BYTE_COLON   = 8'h3A;
   localparam logic [7:0] BYTE_ZERO    = 8'h30;
   localparam logic [7:0] BYTE_NINE    = 8'h39;
   localparam logic [7:0] BYTE_UPPER_A = 8'h41;
   localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT     = 8'h20;

   // content-length line matcher states; 1 to 13 are positions in the name
   localparam logic [LINE_STATE_WIDTH-1:0] LM_LINE_START = 5'd0;
   localparam logic [LINE_STATE_WIDTH-1:0] LM_NAME_DONE  = 5'd14;
   localparam logic [LINE_STATE_WIDTH-1:0] LM_VAL_PRE    = 5'd15;
   localparam logic [LINE_STATE_WIDTH-1:0] LM_VAL_DIG    = 5'd16;
   localparam logic [LINE_STATE_WIDTH-1:0] LM_VAL_END    = 5'd17;
   localparam logic [LINE_STATE_WIDTH-1:0] LM_SKIP       = 5'd18;

   typedef enum logic [2:0] {
      PH_START,
      PH_HUNT,
      PH_FHDR,
      PH_FPAY,
      PH_HEAD,
      PH_BODY
   } rrf_phase_type;

   typedef enum logic [2:0] {
      TERM_IDLE,
      TERM_CR,
      TERM_CRLF,
      TERM_CRLFCR,
      TERM_LF
   } rrf_term_type;

   typedef enum logic [1:0] {
      KIND_HUNT,
      KIND_FRAME,
      KIND_HEADER,
      KIND_BODY
   } rrf_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_HEADER_LIMIT,
      ERR_LENGTH
   } rrf_err_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRAME_SKIP,
      CSR_HEADER_LIMIT
   } rrf_csr_index_type;

   // byte leaving the input register toward the parser
   typedef struct packed {
      logic       advance;
      logic [7:0] data_byte;
   } rrf_item_type;

   // one tagged result
   typedef struct packed {
      logic [7:0]   out_byte;
      rrf_kind_type byte_kind;
      logic         response_start;
      logic         response_end;
      rrf_err_type  error_code;
   } rrf_result_type;

   // lower-case "content-length", one character per position
   function automatic logic [7:0] rrf_name_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h63;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6E;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h65;
         4'd5:    ch = 8'h6E;
         4'd6:    ch = 8'h74;
         4'd7:    ch = 8'h2D;
         4'd8:    ch = 8'h6C;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h6E;
         4'd11:   ch = 8'h67;
         4'd12:   ch = 8'h74;
         4'd13:   ch = 8'h68;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- src/rtsp_response_framer_core.sv -----
// top level of the rtsp interleaved-tcp response framer
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | req_data_byte
//   rsp_    | out       | rsp_valid/rsp_stall  | out_byte, byte_kind, start, end, error
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// one byte per cycle sustained while rsp_stall stays low; a byte's result is computed
// from the input register by the one-pass parser and held in the result register,
// from which it leaves on the response channel.
// reset is synchronous: parser at start of response, skip off, header limit 65536.
// while a result is stalled the input register still takes one more byte;
// req_stall rises only when both registers are full and rsp_stall is high.
`include "rtsp_response_framer_core_defines.svh"

module rtsp_response_framer_core #(
   parameter int unsigned LENGTH_WIDTH = rrf_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_out_byte,
   output logic [1:0]                           rsp_byte_kind,
   output logic                                 rsp_response_start,
   output logic                                 rsp_response_end,
   output logic [1:0]                           rsp_error_code,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rrf_pkg::LIMIT_WIDTH-1:0]      csr_data
);
   import rrf_pkg::*;

   logic                   frame_skip;
   logic [LIMIT_WIDTH-1:0] header_limit;
   logic                   out_ready;
   rrf_item_type           item;
   rrf_result_type         result;
   rrf_result_type         rsp_result;

   rrf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .frame_skip   (frame_skip),
      .header_limit (header_limit)
   );

   rrf_input_stage u_input_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .out_ready     (out_ready),
      .item          (item)
   );

   rrf_parser #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .frame_skip   (frame_skip),
      .header_limit (header_limit),
      .result       (result)
   );

   rrf_output_stage u_output_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (item.advance),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // result fields
   assign rsp_out_byte       = rsp_result.out_byte;
   assign rsp_byte_kind      = rsp_result.byte_kind;
   assign rsp_response_start = rsp_result.response_start;
   assign rsp_response_end   = rsp_result.response_end;
   assign rsp_error_code     = rsp_result.error_code;

   // checks
   `RRF_ASSERT_IMPLY(a_end_without_error, rsp_valid && rsp_response_end,
                     rsp_error_code == ERR_NONE, "response end together with an error")
   `RRF_ASSERT_IMPLY(a_start_is_header, rsp_valid && rsp_response_start,
                     rsp_byte_kind == KIND_HEADER, "response start on a non-header byte")
   `RRF_ASSERT_IMPLY(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall,
                     "input stalled while the result side can move")

endmodule

// ----- src/rrf_csr.sv -----
// configuration registers written through the csr channel
module rrf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rrf_pkg::LIMIT_WIDTH-1:0]      csr_data,
   output logic                                 frame_skip,
   output logic [rrf_pkg::LIMIT_WIDTH-1:0]      header_limit
);
   import rrf_pkg::*;

   logic                   skip_ff;
   logic [LIMIT_WIDTH-1:0] limit_ff;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= 1'b0;
         limit_ff <= LIMIT_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_SKIP:   skip_ff  <= csr_data[0];
            CSR_HEADER_LIMIT: limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign frame_skip   = skip_ff;
   assign header_limit = limit_ff;

endmodule

// ----- src/rrf_input_stage.sv -----
// input register for received bytes and the request-side handshake
module rrf_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  out_ready,
   output rrf_pkg::rrf_item_type item
);
   import rrf_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] byte_ff;
   logic       advance;
   logic       accept;

   // byte moves on when the result register can take its result
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
      end
   end

   assign item.advance   = advance;
   assign item.data_byte = byte_ff;

endmodule

// ----- src/rrf_parser.sv -----
// single-pass byte parser: interleaved frame skip, prefix hunt, header and body framing
`include "rtsp_response_framer_core_defines.svh"

module rrf_parser #(
   parameter int unsigned LENGTH_WIDTH = rrf_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrf_pkg::rrf_item_type            item,
   input  logic                             frame_skip,
   input  logic [rrf_pkg::LIMIT_WIDTH-1:0]  header_limit,
   output rrf_pkg::rrf_result_type          result
);
   import rrf_pkg::*;

   localparam int unsigned SUM_WIDTH = LENGTH_WIDTH + 4;

   // parser state
   rrf_phase_type                phase_ff, phase_in;
   logic [1:0]                   fhc_ff, fhc_in;
   logic [FRAME_LEN_WIDTH-1:0]   frame_rem_ff, frame_rem_in;
   logic [39:0]                  window_ff, window_in;
   rrf_term_type                 term_ff, term_in;
   logic [LIMIT_WIDTH-1:0]       hdr_count_ff, hdr_count_in;
   logic [LINE_STATE_WIDTH-1:0]  line_ff, line_in;
   logic [LENGTH_WIDTH-1:0]      accum_ff, accum_in;
   logic                         len_seen_ff, len_seen_in;
   logic [LENGTH_WIDTH-1:0]      body_rem_ff, body_rem_in;

   // byte classification
   logic [7:0]                   b;
   logic [7:0]                   lower_b;
   logic                         is_cr, is_lf, is_blank, is_digit;
   logic [SUM_WIDTH-1:0]         accum_ext;
   logic [SUM_WIDTH-1:0]         digit_sum;
   logic                         digit_ovf;
   logic [LIMIT_WIDTH-1:0]       limit_eff;

   // per-byte working values
   rrf_phase_type                phase_eff;
   logic                         run_head;
   logic [LIMIT_WIDTH-1:0]       base_count;
   logic [LINE_STATE_WIDTH-1:0]  base_line;
   rrf_term_type                 base_term;
   logic [LIMIT_WIDTH-1:0]       head_count;
   logic [39:0]                  win_shift;
   logic [FRAME_LEN_WIDTH-1:0]   fr_next;
   logic [LENGTH_WIDTH-1:0]      body_dec;
   logic                         line_bad;
   logic                         term_done;
   logic                         do_restart;
   rrf_kind_type                 kind;
   logic                         start_flag;
   logic                         end_flag;
   rrf_err_type                  err;

   assign b        = item.data_byte;
   assign lower_b  = (b >= BYTE_UPPER_A && b <= BYTE_UPPER_Z) ? (b | CASE_BIT) : b;
   assign is_cr    = (b == BYTE_CR);
   assign is_lf    = (b == BYTE_LF);
   assign is_blank = (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_VT) ||
                     (b == BYTE_FF) || (b == BYTE_CR);
   assign is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);

   // accum * 10 + digit, overflow when anything lands above the length width
   assign accum_ext = SUM_WIDTH'(accum_ff);
   assign digit_sum = (accum_ext << 3) + (accum_ext << 1) + SUM_WIDTH'(b[3:0]);
   assign digit_ovf = |digit_sum[SUM_WIDTH-1:LENGTH_WIDTH];

   // clamp the configured header limit
   assign limit_eff = (header_limit < LIMIT_MIN) ? LIMIT_MIN :
                      (header_limit > LIMIT_MAX) ? LIMIT_MAX : header_limit;

   // next state and result for the byte in the input register
   always_comb begin
      phase_in     = phase_ff;
      fhc_in       = fhc_ff;
      frame_rem_in = frame_rem_ff;
      window_in    = window_ff;
      term_in      = term_ff;
      hdr_count_in = hdr_count_ff;
      line_in      = line_ff;
      accum_in     = accum_ff;
      len_seen_in  = len_seen_ff;
      body_rem_in  = body_rem_ff;

      kind       = KIND_HUNT;
      start_flag = 1'b0;
      end_flag   = 1'b0;
      err        = ERR_NONE;
      run_head   = 1'b0;
      base_count = hdr_count_ff;
      base_line  = line_ff;
      base_term  = term_ff;
      head_count = hdr_count_ff;
      win_shift  = {window_ff[31:0], b};
      fr_next    = frame_rem_ff;
      body_dec   = body_rem_ff;
      line_bad   = 1'b0;
      term_done  = 1'b0;
      do_restart = 1'b0;

      // mode is chosen on the first byte of a response
      phase_eff = phase_ff;
      if (phase_ff == PH_START) begin
         if (frame_skip) begin
            phase_eff = PH_HUNT;
         end else begin
            phase_eff  = PH_HEAD;
            start_flag = 1'b1;
         end
         phase_in = phase_eff;
      end

      unique case (phase_eff)
         PH_HUNT: begin
            if (b == BYTE_DOLLAR) begin
               kind      = KIND_FRAME;
               window_in = '0;
               fhc_in    = 2'd0;
               phase_in  = PH_FHDR;
            end else begin
               window_in = win_shift;
               if (win_shift == PREFIX_WORD) begin
                  kind       = KIND_HEADER;
                  start_flag = 1'b1;
                  window_in  = '0;
                  phase_in   = PH_HEAD;
                  run_head   = 1'b1;
                  base_count = PREFIX_COUNT;
                  base_line  = LM_SKIP;
                  base_term  = TERM_IDLE;
               end
            end
         end
         PH_FHDR: begin
            // channel byte, then big-endian length
            kind = KIND_FRAME;
            case (fhc_ff)
               2'd1:    fr_next = {b, 8'h00};
               2'd2:    fr_next = {frame_rem_ff[15:8], b};
               default: fr_next = frame_rem_ff;
            endcase
            frame_rem_in = fr_next;
            if (fhc_ff[1]) begin
               fhc_in   = 2'd0;
               phase_in = (fr_next != '0) ? PH_FPAY : PH_HUNT;
            end else begin
               fhc_in = fhc_ff + 2'd1;
            end
         end
         PH_FPAY: begin
            kind = KIND_FRAME;
            if (frame_rem_ff != '0) begin
               fr_next = frame_rem_ff - 16'd1;
            end
            frame_rem_in = fr_next;
            if (fr_next == '0) begin
               phase_in = PH_HUNT;
            end
         end
         PH_HEAD: begin
            kind     = KIND_HEADER;
            run_head = 1'b1;
         end
         PH_BODY: begin
            kind = KIND_BODY;
            if (body_rem_ff != '0) begin
               body_dec = body_rem_ff - LENGTH_WIDTH'(1);
            end
            body_rem_in = body_dec;
            if (body_dec == '0) begin
               end_flag   = 1'b1;
               do_restart = 1'b1;
            end
         end
         default: begin
            do_restart = 1'b1;
         end
      endcase

      // header byte: content-length matcher, terminator tracker, limit check
      if (run_head) begin
         head_count   = base_count + 17'd1;
         hdr_count_in = head_count;
         // matcher holds its state unless a byte moves it
         line_in      = base_line;

         if (is_lf) begin
            line_in  = LM_LINE_START;
            line_bad = (base_line == LM_VAL_PRE);
         end else if (base_line < LM_NAME_DONE) begin
            if (base_line == LM_LINE_START && len_seen_ff) begin
               line_in = LM_SKIP;
            end else if (base_line == LM_LINE_START && is_blank) begin
               line_in = LM_LINE_START;
            end else if (lower_b == rrf_name_char(base_line[3:0])) begin
               line_in = base_line + 5'd1;
            end else begin
               line_in = LM_SKIP;
            end
         end else if (base_line == LM_NAME_DONE) begin
            if (b == BYTE_COLON) begin
               line_in     = LM_VAL_PRE;
               len_seen_in = 1'b1;
               accum_in    = '0;
            end else if (!is_blank) begin
               line_in = LM_SKIP;
            end
         end else if (base_line == LM_VAL_PRE) begin
            if (!is_blank) begin
               if (!is_digit) begin
                  line_bad = 1'b1;
               end else begin
                  line_in = LM_VAL_DIG;
                  if (digit_ovf) begin
                     line_bad = 1'b1;
                  end else begin
                     accum_in = digit_sum[LENGTH_WIDTH-1:0];
                  end
               end
            end
         end else if (base_line == LM_VAL_DIG) begin
            if (is_digit) begin
               if (digit_ovf) begin
                  line_bad = 1'b1;
               end else begin
                  accum_in = digit_sum[LENGTH_WIDTH-1:0];
               end
            end else begin
               line_in = LM_VAL_END;
            end
         end

         if (line_bad) begin
            err        = ERR_LENGTH;
            do_restart = 1'b1;
         end else begin
            // crlfcrlf, crlflf or lflf tracker
            if (is_cr) begin
               term_in = (base_term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
            end else if (is_lf) begin
               if (base_term == TERM_CRLF || base_term == TERM_CRLFCR ||
                   base_term == TERM_LF) begin
                  term_done = 1'b1;
               end else begin
                  term_in = (base_term == TERM_CR) ? TERM_CRLF : TERM_LF;
               end
            end else begin
               term_in = TERM_IDLE;
            end

            if (term_done) begin
               if (len_seen_in && accum_in != '0) begin
                  body_rem_in = accum_in;
                  phase_in    = PH_BODY;
               end else begin
                  end_flag   = 1'b1;
                  do_restart = 1'b1;
               end
            end else if (head_count >= limit_eff) begin
               err        = ERR_HEADER_LIMIT;
               do_restart = 1'b1;
            end
         end
      end

      // back to the start of a response
      if (do_restart) begin
         phase_in     = PH_START;
         fhc_in       = 2'd0;
         frame_rem_in = '0;
         window_in    = '0;
         term_in      = TERM_IDLE;
         hdr_count_in = '0;
         line_in      = LM_LINE_START;
         accum_in     = '0;
         len_seen_in  = 1'b0;
         body_rem_in  = '0;
      end

      result.out_byte       = b;
      result.byte_kind      = kind;
      result.response_start = start_flag;
      result.response_end   = end_flag;
      result.error_code     = err;
   end

   // state registers, updated once per byte transfer into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         fhc_ff       <= 2'd0;
         frame_rem_ff <= '0;
         window_ff    <= '0;
         term_ff      <= TERM_IDLE;
         hdr_count_ff <= '0;
         line_ff      <= LM_LINE_START;
         accum_ff     <= '0;
         len_seen_ff  <= 1'b0;
         body_rem_ff  <= '0;
      end else if (item.advance) begin
         phase_ff     <= phase_in;
         fhc_ff       <= fhc_in;
         frame_rem_ff <= frame_rem_in;
         window_ff    <= window_in;
         term_ff      <= term_in;
         hdr_count_ff <= hdr_count_in;
         line_ff      <= line_in;
         accum_ff     <= accum_in;
         len_seen_ff  <= len_seen_in;
         body_rem_ff  <= body_rem_in;
      end
   end

   // checks
   `RRF_ASSERT_IMPLY(a_body_nonzero, phase_ff == PH_BODY, body_rem_ff != '0,
                     "body phase with no bytes left")
   `RRF_ASSERT_IMPLY(a_frame_nonzero, phase_ff == PH_FPAY, frame_rem_ff != '0,
                     "frame payload phase with no bytes left")
   `RRF_ASSERT_NEXT(a_restart_after_end,
                    item.advance && (result.response_end || result.error_code != ERR_NONE),
                    phase_ff == PH_START, "no restart after end or error")

endmodule

// ----- src/rrf_output_stage.sv -----
// result register and the response-side handshake
module rrf_output_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  rrf_pkg::rrf_result_type result,
   output logic                    out_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rrf_pkg::rrf_result_type rsp_result
);
   import rrf_pkg::*;

   logic           out_valid_ff;
   logic           out_valid_in;
   rrf_result_type result_ff;

   // free when empty or when the held result leaves this cycle
   assign out_ready    = !out_valid_ff || !rsp_stall;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

endmodule
